[sv/lpsc_pkg.sv]
// shared types and constants of the length prefix to start code framer
package lpsc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
        logic       error_flag;
    } t_out_beat;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_BYTE_ERR = 2'd1;
    localparam logic [1:0] CMD_MARKER   = 2'd2;
    localparam logic [1:0] CMD_START    = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam int         Q_DEPTH = 4;
    localparam int         Q_PTR_W = 2;
    localparam int         Q_CNT_W = 3;

    localparam int         STEP_W          = 2;
    localparam logic [1:0] START_LAST_STEP = 2'd3;
    localparam logic [7:0] START_CODE_ZERO = 8'h00;
    localparam logic [7:0] START_CODE_ONE  = 8'h01;

endpackage

[sv/lpsc_front.sv]
// front end: parses length fields and maps input beats to commands
module lpsc_front #(
    parameter int LENGTH_FIELD_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lpsc_pkg::t_in_beat i_in_data,
    input  lpsc_pkg::t_q_stat i_q_stat,
    output logic              o_in_stall,
    output lpsc_pkg::t_push   o_push
);
    import lpsc_pkg::*;

    localparam int AW = 8 * LENGTH_FIELD_BYTES;
    localparam int CW = (LENGTH_FIELD_BYTES > 1) ? $clog2(LENGTH_FIELD_BYTES) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(LENGTH_FIELD_BYTES - 1);

    localparam logic [1:0] PH_LENGTH  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DISCARD = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_rem, n_rem;

    logic          accept;
    logic [AW+7:0] shifted;
    logic [AW-1:0] new_len;
    logic          fend;

    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign fend       = i_in_data.frame_end;
    assign shifted    = {r_acc, i_in_data.data_byte};
    assign new_len    = shifted[AW-1:0];

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_rem   = r_rem;
        o_push  = '0;
        if (accept) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    o_push.push     = 1'b1;
                    o_push.cmd.data = i_in_data.data_byte;
                    if (r_rem == AW'(1)) begin
                        o_push.cmd.kind = CMD_BYTE;
                        o_push.cmd.last = fend;
                        n_phase         = PH_LENGTH;
                        n_rem           = '0;
                    end else if (fend) begin
                        o_push.cmd.kind = CMD_BYTE_ERR;
                        n_phase         = PH_LENGTH;
                        n_rem           = '0;
                    end else begin
                        o_push.cmd.kind = CMD_BYTE;
                        n_rem           = r_rem - AW'(1);
                    end
                end
                PH_DISCARD: begin
                    if (fend) begin
                        o_push.push     = 1'b1;
                        o_push.cmd.kind = CMD_MARKER;
                        o_push.cmd.last = 1'b1;
                        o_push.cmd.err  = 1'b1;
                        n_phase         = PH_LENGTH;
                    end
                end
                default: begin
                    n_phase = PH_LENGTH;
                    if (r_cnt != CNT_LAST) begin
                        if (fend) begin
                            o_push.push     = 1'b1;
                            o_push.cmd.kind = CMD_MARKER;
                            o_push.cmd.last = 1'b1;
                            n_cnt           = '0;
                            n_acc           = '0;
                        end else begin
                            n_cnt = r_cnt + CW'(1);
                            n_acc = new_len;
                        end
                    end else begin
                        o_push.push = 1'b1;
                        n_cnt       = '0;
                        n_acc       = '0;
                        if (new_len == '0) begin
                            o_push.cmd.kind = CMD_MARKER;
                            o_push.cmd.last = fend;
                            o_push.cmd.err  = 1'b1;
                            n_phase         = fend ? PH_LENGTH : PH_DISCARD;
                        end else if (fend) begin
                            o_push.cmd.kind = CMD_MARKER;
                            o_push.cmd.last = 1'b1;
                            o_push.cmd.err  = 1'b1;
                        end else begin
                            o_push.cmd.kind = CMD_START;
                            n_rem           = new_len;
                            n_phase         = PH_PAYLOAD;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LENGTH;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

endmodule

[sv/lpsc_queue.sv]
// short command queue between front and back
module lpsc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpsc_pkg::t_push   i_push,
    input  logic              i_pop,
    output lpsc_pkg::t_cmd    o_head,
    output lpsc_pkg::t_q_stat o_stat
);
    import lpsc_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push.push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

endmodule

[sv/lpsc_back.sv]
// back end: expands commands into output beats behind an output register
module lpsc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpsc_pkg::t_cmd      i_head,
    input  lpsc_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output lpsc_pkg::t_out_beat o_out_data
);
    import lpsc_pkg::*;

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    t_out_beat beat;
    logic      last_step;
    logic      load;

    always_comb begin
        beat      = '0;
        last_step = 1'b1;
        unique case (i_head.kind)
            CMD_BYTE: begin
                beat.out_byte   = i_head.data;
                beat.byte_valid = 1'b1;
                beat.out_last   = i_head.last;
            end
            CMD_BYTE_ERR: begin
                if (r_step == '0) begin
                    beat.out_byte   = i_head.data;
                    beat.byte_valid = 1'b1;
                    last_step       = 1'b0;
                end else begin
                    beat.out_last   = 1'b1;
                    beat.error_flag = 1'b1;
                end
            end
            CMD_MARKER: begin
                beat.out_last   = i_head.last;
                beat.error_flag = i_head.err;
            end
            CMD_START: begin
                beat.out_byte   = (r_step == START_LAST_STEP) ? START_CODE_ONE
                                                              : START_CODE_ZERO;
                beat.byte_valid = 1'b1;
                last_step       = (r_step == START_LAST_STEP);
            end
        endcase
    end

    assign load  = !r_out_valid || !i_out_stall;
    assign o_pop = load && !i_q_stat.empty && last_step;

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load) begin
            n_out_valid = !i_q_stat.empty;
            if (!i_q_stat.empty) begin
                n_out  = beat;
                n_step = last_step ? '0 : r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/length_prefix_to_start_code_framer.sv]
// top level of the length prefix to start code framer
//
// input channel: one byte of a length-prefixed frame per beat, frame_end
// on the last byte. each unit's big-endian length field (LENGTH_FIELD_BYTES
// bytes) is replaced by the start code 00 00 00 01, payload bytes pass
// through. zero or truncated units give a bare marker beat (byte_valid 0,
// error_flag 1) and the rest of the frame is dropped; a frame ending inside
// a length field closes with a bare marker without error.
// output channel: one result per beat, out_last on the frame's final beat.
// an accepted byte passes through the command queue and then the output register.
// throughput: one input beat per cycle while the queue is not full; a length field's last byte expands
// to four start code beats, so the output side sets the pace there. a
// four-entry command queue sits between parser and beat generator.
// a stall on the output holds the output register; the queue keeps taking
// input until it fills, then o_in_stall rises.
// reset: synchronous, active low; clears parser state, queue and output
// valid, and the block starts in the length phase.
module length_prefix_to_start_code_framer #(
    parameter int LENGTH_FIELD_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lpsc_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lpsc_pkg::t_out_beat o_out_data
);
    import lpsc_pkg::*;

    t_push   push;
    t_cmd    head;
    t_q_stat q_stat;
    logic    pop;

    lpsc_front #(
        .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_stat   (q_stat),
        .o_in_stall (o_in_stall),
        .o_push     (push)
    );

    lpsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    lpsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    a_error_is_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_flag) |->
            (!o_out_data.byte_valid && o_out_data.out_byte == 8'h00))
        else $error("error marker carries data");

endmodule

[dv/length_prefix_to_start_code_framer_tb.sv]
// testbench for the length prefix to start code framer: directed and random frames and scoreboard
module length_prefix_to_start_code_framer_tb;
    import lpsc_pkg::*;

    localparam int LEN_BYTES   = 4;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 24;

    typedef enum logic [1:0] {
        PARSE_LENGTH  = 2'd0,
        PARSE_PAYLOAD = 2'd1,
        PARSE_DISCARD = 2'd2
    } t_parse_phase;

    typedef enum int {
        TAIL_EXACT,
        TAIL_PAYLOAD,
        TAIL_LENGTH,
        TAIL_PARTIAL,
        TAIL_ZERO,
        TAIL_DISCARD
    } t_frame_tail;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_data = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_data;

    t_in_beat  pending_beats[$];
    t_out_beat expected_out[$];

    t_parse_phase parse_phase = PARSE_LENGTH;
    int           length_cnt = 0;
    logic [31:0]  length_acc = '0;
    logic [31:0]  payload_left = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    int mismatch_count = 0;
    int items_queued = 0;
    int frames_sent = 0;
    int bad_frames = 0;
    int beats_in = 0;
    int beats_out = 0;
    int markers_out = 0;

    length_prefix_to_start_code_framer #(
        .LENGTH_FIELD_BYTES(LEN_BYTES)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void push_expect(input logic [7:0] b, input logic valid,
                                        input logic last, input logic err);
        t_out_beat beat;
        beat.out_byte   = b;
        beat.byte_valid = valid;
        beat.out_last   = last;
        beat.error_flag = err;
        expected_out.push_back(beat);
    endfunction

    function automatic void clear_parser();
        parse_phase  = PARSE_LENGTH;
        length_cnt   = 0;
        length_acc   = '0;
        payload_left = '0;
    endfunction

    // expected output beats for one accepted input byte
    function automatic void annexb_step(input t_in_beat beat);
        case (parse_phase)
            PARSE_PAYLOAD: begin
                payload_left = payload_left - 32'd1;
                if (payload_left == '0) begin
                    push_expect(beat.data_byte, 1'b1, beat.frame_end, 1'b0);
                    clear_parser();
                end else if (beat.frame_end) begin
                    push_expect(beat.data_byte, 1'b1, 1'b0, 1'b0);
                    push_expect(8'h00, 1'b0, 1'b1, 1'b1);
                    clear_parser();
                end else begin
                    push_expect(beat.data_byte, 1'b1, 1'b0, 1'b0);
                end
            end
            PARSE_DISCARD: begin
                if (beat.frame_end) begin
                    push_expect(8'h00, 1'b0, 1'b1, 1'b1);
                    clear_parser();
                end
            end
            default: begin
                parse_phase = PARSE_LENGTH;
                length_acc  = {length_acc[23:0], beat.data_byte};
                length_cnt  = length_cnt + 1;
                if (length_cnt < LEN_BYTES) begin
                    if (beat.frame_end) begin
                        push_expect(8'h00, 1'b0, 1'b1, 1'b0);
                        clear_parser();
                    end
                end else if (length_acc == '0) begin
                    push_expect(8'h00, 1'b0, beat.frame_end, 1'b1);
                    if (beat.frame_end) begin
                        clear_parser();
                    end else begin
                        parse_phase = PARSE_DISCARD;
                        length_cnt  = 0;
                    end
                end else if (beat.frame_end) begin
                    push_expect(8'h00, 1'b0, 1'b1, 1'b1);
                    clear_parser();
                end else begin
                    push_expect(START_CODE_ZERO, 1'b1, 1'b0, 1'b0);
                    push_expect(START_CODE_ZERO, 1'b1, 1'b0, 1'b0);
                    push_expect(START_CODE_ZERO, 1'b1, 1'b0, 1'b0);
                    push_expect(START_CODE_ONE, 1'b1, 1'b0, 1'b0);
                    payload_left = length_acc;
                    length_acc   = '0;
                    length_cnt   = 0;
                    parse_phase  = PARSE_PAYLOAD;
                end
            end
        endcase
    endfunction

    function automatic void push_item(input logic [7:0] b, input logic fend);
        t_in_beat beat;
        beat.data_byte = b;
        beat.frame_end = fend;
        pending_beats.push_back(beat);
        items_queued++;
    endfunction

    function automatic void push_length(input logic [31:0] len, input logic fend_last);
        for (int i = LEN_BYTES - 1; i >= 0; i--) begin
            push_item(len[8*i +: 8], fend_last && (i == 0));
        end
    endfunction

    task automatic add_frame(input t_frame_tail tail, input int n_full, input int max_len);
        int          len;
        int          k;
        logic [31:0] big;
        t_in_beat    junk;
        if (tail == TAIL_EXACT && n_full < 1) begin
            n_full = 1;
        end
        for (int u = 0; u < n_full; u++) begin
            len = $urandom_range(max_len, 1);
            push_length(len, 1'b0);
            for (int j = 0; j < len; j++) begin
                push_item(8'($urandom_range(255)),
                          tail == TAIL_EXACT && u == n_full - 1 && j == len - 1);
            end
        end
        case (tail)
            TAIL_PAYLOAD: begin
                big = ($urandom_range(7) == 0) ? $urandom : $urandom_range(40, 2);
                if (big < 2) begin
                    big = 2;
                end
                k = $urandom_range((big > 7) ? 6 : big - 1, 1);
                push_length(big, 1'b0);
                for (int j = 0; j < k; j++) begin
                    push_item(8'($urandom_range(255)), j == k - 1);
                end
            end
            TAIL_LENGTH: begin
                big = $urandom;
                if (big == '0) begin
                    big = 1;
                end
                push_length(big, 1'b1);
            end
            TAIL_PARTIAL: begin
                k = $urandom_range(LEN_BYTES - 1, 1);
                for (int j = 0; j < k; j++) begin
                    push_item(8'($urandom_range(255)), j == k - 1);
                end
            end
            TAIL_ZERO: begin
                push_length('0, 1'b1);
            end
            TAIL_DISCARD: begin
                push_length('0, 1'b0);
                k = $urandom_range(5, 1);
                // dropped bytes, not counted as stimulus
                for (int j = 0; j < k; j++) begin
                    junk.data_byte = 8'($urandom_range(255));
                    junk.frame_end = (j == k - 1);
                    pending_beats.push_back(junk);
                end
            end
            default: ;
        endcase
        frames_sent++;
        if (tail != TAIL_EXACT && tail != TAIL_PARTIAL) begin
            bad_frames++;
        end
    endtask

    task automatic add_random_frame();
        int          r;
        t_frame_tail tail;
        r = $urandom_range(9);
        case (r)
            5:       tail = TAIL_PAYLOAD;
            6:       tail = TAIL_LENGTH;
            7:       tail = TAIL_PARTIAL;
            8:       tail = TAIL_ZERO;
            9:       tail = TAIL_DISCARD;
            default: tail = TAIL_EXACT;
        endcase
        add_frame(tail, (tail == TAIL_EXACT) ? $urandom_range(3, 1) : $urandom_range(2, 0),
                  12);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_out.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
        int goal;
        wait_drained();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (with_hold) begin
            hold_requests++;
        end
        goal = items_queued + PHASE_ITEMS;
        while (items_queued < goal) begin
            add_random_frame();
        end
    endtask

    task automatic report_mismatch(input string what, input t_out_beat want,
                                   input t_out_beat got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch %s: expected byte %02h valid %0b last %0b err %0b",
                     what, want.out_byte, want.byte_valid, want.out_last, want.error_flag);
            $display("    got byte %02h valid %0b last %0b err %0b",
                     got.out_byte, got.byte_valid, got.out_last, got.error_flag);
        end
    endtask

    // sender
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                annexb_step(in_data);
                beats_in++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_beats.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk) begin
        t_out_beat want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                beats_out++;
                if (!out_data.byte_valid) begin
                    markers_out++;
                end
                if (expected_out.size() == 0) begin
                    report_mismatch("unexpected beat", '0, out_data);
                end else begin
                    want = expected_out.pop_front();
                    if (out_data.out_byte !== want.out_byte
                            || out_data.byte_valid !== want.byte_valid
                            || out_data.out_last !== want.out_last
                            || out_data.error_flag !== want.error_flag) begin
                        report_mismatch("wrong beat", want, out_data);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames
        push_length(32'd2, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b1);
        push_length('0, 1'b1);
        push_item(8'hA5, 1'b1);
        push_length(32'hFFFF_FFFF, 1'b0);
        push_item(8'h5A, 1'b1);
        push_length(32'd3, 1'b1);
        push_length('0, 1'b0);
        pending_beats.push_back('{data_byte: 8'hFF, frame_end: 1'b1});
        frames_sent += 6;
        bad_frames  += 4;

        run_phase(0, 0, 1'b1);
        run_phase(73, 0, 1'b0);
        run_phase(0, 73, 1'b0);
        run_phase(30, 30, 1'b0);
        run_phase(0, 0, 1'b0);

        wait_drained();
        repeat (10) @(negedge clk);
        mismatch_count += expected_out.size();

        $display("covered %0d frames (%0d ending in error), %0d bytes in",
                 frames_sent, bad_frames, beats_in);
        $display("%0d beats out with %0d markers; idle phases none, sender 73%%, %s%0d",
                 beats_out, markers_out, "receiver 73%, both 30%, output hold ",
                 HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[files.f]
sv/lpsc_pkg.sv
sv/lpsc_front.sv
sv/lpsc_queue.sv
sv/lpsc_back.sv
sv/length_prefix_to_start_code_framer.sv
dv/length_prefix_to_start_code_framer_tb.sv
